FILE: sv/ubr_pkg.sv
// Shared constants and controller/datapath interface types for the
// unbiased bounded random block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ubr_pkg;

  // Bits of each entropy word that take part in a draw.
  localparam int DRAW_BITS = 64;
  // Width of the bit counter in the remainder unit.
  localparam int CNT_W     = $clog2(DRAW_BITS);
  // Span of a range: 1 .. 2^32.
  localparam int SPAN_W    = 33;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_ENTROPY = 1'b1;

  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_BELOW = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture_req;  // store span/offset, start remainder of the draw mask
    logic start_draw;   // start remainder of the entropy word
    logic step;         // one remainder step
    logic commit_thr;   // store threshold, mark the request pending
    logic latch_bad;    // stage a bad-argument result, drop the request
    logic latch_val;    // stage a value result, drop the request
    logic out_load;     // move the staged result into the output register
  } ubr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_bad;   // request on the input ports has bad arguments
    logic draw_ok;   // entropy word on the input ports passes the threshold
    logic div_last;  // remainder unit is on its final step
  } ubr_sts_t;

endpackage

`default_nettype wire

FILE: sv/ubr_dp.sv
// Datapath: request decode, stored range, bit-serial remainder unit and
// result/output registers. Depends on ubr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ubr_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    mode,
  input  wire logic signed [31:0]            first_arg,
  input  wire logic signed [31:0]            second_arg,
  input  wire logic [63:0]                   entropy_word,
  input  wire ubr_pkg::ubr_cmd_t             cmd,
  output ubr_pkg::ubr_sts_t                  sts,
  output logic                               status,
  output logic signed [31:0]                 value
);

  logic                                  pending;
  logic [ubr_pkg::SPAN_W-1:0]            span;
  logic [31:0]                           threshold;
  logic [31:0]                           offset;
  logic [ubr_pkg::SPAN_W-1:0]            rem;
  logic [ubr_pkg::DRAW_BITS-1:0]         dividend;
  logic [ubr_pkg::CNT_W-1:0]             cnt;
  logic                                  res_status;
  logic [31:0]                           res_value;

  logic [ubr_pkg::SPAN_W-1:0]            req_span;
  logic [31:0]                           req_offset;
  logic                                  req_bad;
  logic signed [32:0]                    diff;
  logic [ubr_pkg::DRAW_BITS-1:0]         word;
  logic [ubr_pkg::SPAN_W:0]              trial;
  logic [ubr_pkg::SPAN_W:0]              trial_sub;
  logic [ubr_pkg::SPAN_W-1:0]            rem_next;
  logic [ubr_pkg::SPAN_W-1:0]            rem_inc;

  // Decode the request on the ports.
  always_comb begin
    diff       = 33'(second_arg) - 33'(first_arg);
    req_span   = '0;
    req_offset = '0;
    req_bad    = 1'b0;
    case (mode)
      ubr_pkg::MODE_FULL: begin
        req_span = ubr_pkg::SPAN_W'(ubr_pkg::INT_MAX) + 1'b1;
      end
      ubr_pkg::MODE_BELOW: begin
        req_bad  = (first_arg <= 0);
        req_span = ubr_pkg::SPAN_W'(unsigned'(first_arg));
      end
      ubr_pkg::MODE_RANGE: begin
        req_bad    = (second_arg < first_arg);
        req_span   = unsigned'(diff) + 1'b1;
        req_offset = first_arg;
      end
      default: begin
        req_bad = 1'b1;
      end
    endcase
  end

  assign word = entropy_word[ubr_pkg::DRAW_BITS-1:0];

  // One restoring remainder step: shift in the next dividend bit.
  always_comb begin
    trial     = {rem, dividend[ubr_pkg::DRAW_BITS-1]};
    trial_sub = trial - {1'b0, span};
    rem_next  = (trial >= {1'b0, span}) ? trial_sub[ubr_pkg::SPAN_W-1:0]
                                        : trial[ubr_pkg::SPAN_W-1:0];
    rem_inc   = rem + 1'b1;
  end

  assign sts.req_bad  = req_bad;
  assign sts.draw_ok  = pending && (word >= ubr_pkg::DRAW_BITS'(threshold));
  assign sts.div_last = (cnt == ubr_pkg::CNT_W'(ubr_pkg::DRAW_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (cmd.commit_thr) begin
      pending <= 1'b1;
    end else if (cmd.latch_bad || cmd.latch_val) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_req) begin
      span     <= req_span;
      offset   <= req_offset;
      dividend <= '1;
      rem      <= '0;
      cnt      <= '0;
    end else if (cmd.start_draw) begin
      dividend <= word;
      rem      <= '0;
      cnt      <= '0;
    end else if (cmd.step) begin
      dividend <= dividend << 1;
      rem      <= rem_next;
      cnt      <= cnt + 1'b1;
    end
    // 2^DRAW_BITS mod span = ((mask mod span) + 1) mod span.
    if (cmd.commit_thr) begin
      threshold <= (rem_inc == span) ? 32'd0 : rem_inc[31:0];
    end
    if (cmd.latch_bad) begin
      res_status <= ubr_pkg::STATUS_BAD;
      res_value  <= '0;
    end else if (cmd.latch_val) begin
      res_status <= ubr_pkg::STATUS_OK;
      res_value  <= offset + rem[31:0];
    end
    if (cmd.out_load) begin
      status <= res_status;
      value  <= res_value;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ubr_ctrl.sv
// Controller: sequences requests, draws and the output handshake.
// Depends on ubr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ubr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              opcode,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire ubr_pkg::ubr_sts_t sts,
  output ubr_pkg::ubr_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   div_draw;
  logic   div_draw_next;
  logic   in_take;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    div_draw_next = div_draw;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (opcode == ubr_pkg::OP_REQUEST) begin
            if (sts.req_bad) begin
              cmd.latch_bad = 1'b1;
              state_next    = ST_EMIT;
            end else begin
              cmd.capture_req = 1'b1;
              div_draw_next   = 1'b0;
              state_next      = ST_DIV;
            end
          end else if (sts.draw_ok) begin
            cmd.start_draw = 1'b1;
            div_draw_next  = 1'b1;
            state_next     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (div_draw) begin
          cmd.latch_val = 1'b1;
          state_next    = ST_EMIT;
        end else begin
          cmd.commit_thr = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_draw  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      div_draw <= div_draw_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/unbiased_bounded_random.sv
// Top level of the unbiased bounded random block: joins the controller
// and the datapath. Depends on ubr_pkg, ubr_ctrl and ubr_dp.
//
// Usage:
//   The input channel (in_valid/in_stall) carries two kinds of request.
//   opcode 0 is a new range request (mode, first_arg, second_arg); opcode 1
//   delivers a 64-bit entropy_word. A request is taken when in_valid is
//   high and in_stall is low; in_stall is high whenever the block is busy.
//   A good range request stores the span and offset and computes the
//   rejection threshold with one load, 64 remainder steps and one
//   commit; it produces no result. A bad range request produces a result
//   with status 1 and value 0, staged when it is taken and then moved to
//   the output register. An entropy word with no pending range, or below
//   the threshold, is dropped in the cycle it is taken. An accepted word
//   runs through the same 64-step remainder unit, one dividend bit per
//   cycle, before its result is staged and moved to the output register.
//   The output channel (out_valid/out_stall) holds status and value in a
//   register; while the receiver stalls the result holds, and the block
//   waits with a new result until the register frees up, but still takes
//   a request as soon as the staged result has moved out.
//   Reset (rst, synchronous) clears the pending range and the handshake
//   state; no result is valid after reset.
`timescale 1ns / 1ps
`default_nettype none

module unbiased_bounded_random (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] first_arg,
  input  wire logic signed [31:0] second_arg,
  input  wire logic [63:0]        entropy_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    status,
  output logic signed [31:0]      value
);

  ubr_pkg::ubr_cmd_t cmd;
  ubr_pkg::ubr_sts_t sts;

  // Sequence requests and the output handshake.
  ubr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the range, run the remainder unit, stage and drive the result.
  ubr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .first_arg    (first_arg),
    .second_arg   (second_arg),
    .entropy_word (entropy_word),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .value        (value)
  );

endmodule

`default_nettype wire

FILE: dv/tb_unbiased_bounded_random.sv
// Self-checking testbench for unbiased_bounded_random: random and directed requests
// against a cycle-free predictor of the rejection sampler. Depends on ubr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_unbiased_bounded_random;

  // Mode three has no meaning; the block must answer it as a bad argument.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Generous cycle budget: every request at its full latency plus
  // heavy stalls on both sides, taken several times over.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles to keep watching after the last expected result, covering a
  // dropped entropy word and the remainder unit at full length.
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic               opcode;
    logic [1:0]         mode;
    logic signed [31:0] first_arg;
    logic signed [31:0] second_arg;
    logic [63:0]        entropy_word;
  } rng_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] value;
  } draw_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = ubr_pkg::OP_REQUEST;
  logic [1:0]         mode = ubr_pkg::MODE_FULL;
  logic signed [31:0] first_arg = '0;
  logic signed [31:0] second_arg = '0;
  logic [63:0]        entropy_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               status;
  logic signed [31:0] value;

  unbiased_bounded_random uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .mode         (mode),
    .first_arg    (first_arg),
    .second_arg   (second_arg),
    .entropy_word (entropy_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .value        (value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rng_req_t  req_q[$];     // requests not yet offered to the block
  draw_res_t due_q[$];     // results the block still owes, oldest first
  rng_req_t  cur_req;      // request currently on the input ports
  int        total_items;
  int        taken;
  int        errors;
  int        cycles;

  // Predictor state: the range the block is currently sampling for.
  bit                rng_pending;
  logic [32:0]       rng_span;
  longint unsigned   rng_thr;
  logic [31:0]       rng_offset;

  // Advance the predictor by one accepted request and queue any result it owes.
  task automatic predict_draw(input rng_req_t r);
    longint unsigned mask;
    longint unsigned s;
    longint unsigned word;
    logic [31:0]     off;
    bit              bad;
    mask = (ubr_pkg::DRAW_BITS >= 64) ? '1 : ((64'd1 << ubr_pkg::DRAW_BITS) - 64'd1);
    if (r.opcode == ubr_pkg::OP_REQUEST) begin
      bad = 1'b0;
      off = '0;
      s = 0;
      case (r.mode)
        ubr_pkg::MODE_FULL: begin
          s = longint'(ubr_pkg::INT_MAX) + 1;
        end
        ubr_pkg::MODE_BELOW: begin
          if (r.first_arg <= 0) bad = 1'b1;
          else s = longint'(r.first_arg);
        end
        ubr_pkg::MODE_RANGE: begin
          if (r.second_arg < r.first_arg) begin
            bad = 1'b1;
          end else begin
            s = longint'(r.second_arg) - longint'(r.first_arg) + 1;
            off = r.first_arg;
          end
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        rng_pending = 1'b0;
        due_q.push_back('{ubr_pkg::STATUS_BAD, 32'd0});
      end else begin
        // Threshold is 2^DRAW_BITS mod span, folded to stay inside 64 bits.
        rng_span = s[32:0];
        rng_thr = ((mask % s) + 1) % s;
        rng_offset = off;
        rng_pending = 1'b1;
      end
    end else if (rng_pending && rng_span != 0) begin
      word = r.entropy_word & mask;
      if (word >= rng_thr) begin
        rng_pending = 1'b0;
        due_q.push_back('{ubr_pkg::STATUS_OK, rng_offset + 32'(word % rng_span)});
      end
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Queue a range request; the unused entropy field carries noise.
  task automatic add_request(input logic [1:0] m, input int a, input int b);
    req_q.push_back('{ubr_pkg::OP_REQUEST, m, a, b, rand64()});
  endtask

  // Queue an entropy delivery; the unused request fields carry noise.
  task automatic add_word(input logic [63:0] w);
    req_q.push_back('{ubr_pkg::OP_ENTROPY, 2'($urandom_range(0, 3)), $urandom, $urandom, w});
  endtask

  // Pick a draw that lands both above and below typical thresholds.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 2))
      0:       return rand64();
      1:       return 64'($urandom_range(0, 63));
      default: return {32'd0, $urandom};
    endcase
  endfunction

  // Phase of the run: 0 and 1 use opposite idle mixes, 2 runs flat out.
  function automatic int run_phase();
    if (total_items == 0) return 0;
    return (taken * 3) / total_items;
  endfunction

  function automatic int send_idle_pct();
    case (run_phase())
      0:       return 28;
      1:       return 59;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (run_phase())
      0:       return 59;
      1:       return 28;
      default: return 0;
    endcase
  endfunction

  // Driver: hold a stalled request, advance to the next one after acceptance,
  // and drop valid when the sender idles or runs dry.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_draw(cur_req);
        taken++;
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          cur_req = req_q.pop_front();
          opcode       <= cur_req.opcode;
          mode         <= cur_req.mode;
          first_arg    <= cur_req.first_arg;
          second_arg   <= cur_req.second_arg;
          entropy_word <= cur_req.entropy_word;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every accepted result with the oldest one owed, then
  // decide whether to stall the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("unexpected result: status=%0d value=%0d", status, value);
          errors++;
        end else begin
          if (status !== due_q[0].status) begin
            $error("status mismatch: expected %0d, actual %0d", due_q[0].status, status);
            errors++;
          end
          if (value !== due_q[0].value) begin
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(due_q[0].value), value);
            errors++;
          end
          void'(due_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int n_items;
    int n;
    int lo;
    int hi;
    int k;
    errors = 0;
    taken = 0;
    cycles = 0;
    rng_pending = 1'b0;
    rng_span = '0;
    rng_thr = 0;
    rng_offset = '0;

    // Directed part.
    add_word(rand64());                               // nothing pending: dropped
    add_request(ubr_pkg::MODE_FULL, $urandom, $urandom);
    add_word(64'd0);                                  // lowest draw, zero threshold
    add_request(ubr_pkg::MODE_FULL, $urandom, $urandom);
    add_word('1);                                     // top draw gives INT_MAX
    add_request(ubr_pkg::MODE_BELOW, 0, $urandom);    // n of zero: bad
    add_request(ubr_pkg::MODE_BELOW, 32'h8000_0000, $urandom); // most negative n: bad
    add_request(ubr_pkg::MODE_BELOW, -1, $urandom);
    add_request(ubr_pkg::MODE_BELOW, 3, $urandom);
    add_word(64'd0);                                  // below threshold of one: rejected
    add_word(64'd1);
    add_request(ubr_pkg::MODE_BELOW, ubr_pkg::INT_MAX, $urandom);
    add_word('1);
    add_request(ubr_pkg::MODE_BELOW, 1, $urandom);
    add_word(rand64());
    add_request(ubr_pkg::MODE_RANGE, 32'h8000_0000, ubr_pkg::INT_MAX); // full 2^32 span
    add_word('1);
    add_request(ubr_pkg::MODE_RANGE, 5, 4);           // hi below lo: bad
    add_request(ubr_pkg::MODE_RANGE, ubr_pkg::INT_MAX, 32'h8000_0000);
    add_request(ubr_pkg::MODE_RANGE, -7, -7);
    add_word(rand64());
    add_request(MODE_UNUSED, $urandom, $urandom);
    add_request(ubr_pkg::MODE_BELOW, 10, $urandom);   // replaced before any draw
    add_request(ubr_pkg::MODE_RANGE, 100, 100);
    add_word(rand64());
    add_word(rand64());                               // request already served: dropped
    add_request(ubr_pkg::MODE_BELOW, 5, $urandom);
    add_request(MODE_UNUSED, $urandom, $urandom);     // bad request clears the pending one
    add_word(rand64());
    n_items = req_q.size();

    // Random part: mostly request-then-draws sequences, some noise.
    while (n_items < 850) begin
      if ($urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, 99);
        if (k < 15) begin
          add_request(ubr_pkg::MODE_FULL, $urandom, $urandom);
        end else if (k < 50) begin
          case ($urandom_range(0, 3))
            0:       n = $urandom_range(1, 20);
            1:       n = $urandom_range(1, ubr_pkg::INT_MAX);
            2:       n = ubr_pkg::INT_MAX - $urandom_range(0, 15);
            default: n = 1 << $urandom_range(0, 30);
          endcase
          add_request(ubr_pkg::MODE_BELOW, n, $urandom);
        end else if (k < 90) begin
          lo = $urandom;
          case ($urandom_range(0, 2))
            0: hi = lo + $urandom_range(0, 100);
            1: begin
              hi = $urandom;
              if (hi < lo) begin
                n = lo;
                lo = hi;
                hi = n;
              end
            end
            default: begin
              hi = ubr_pkg::INT_MAX;
              lo = 32'h8000_0000 + $urandom_range(0, 1000);
            end
          endcase
          add_request(ubr_pkg::MODE_RANGE, lo, hi);
        end else begin
          case ($urandom_range(0, 2))
            0:       add_request(ubr_pkg::MODE_BELOW,
                                 -$urandom_range(0, ubr_pkg::INT_MAX), $urandom);
            1:       add_request(ubr_pkg::MODE_RANGE, $urandom_range(1, ubr_pkg::INT_MAX),
                                 -$urandom_range(0, ubr_pkg::INT_MAX));
            default: add_request(MODE_UNUSED, $urandom, $urandom);
          endcase
        end
        n_items++;
        repeat ($urandom_range(1, 4)) begin
          add_word(pick_word());
          n_items++;
        end
      end else if ($urandom_range(0, 1) == 0) begin
        add_word(rand64());
        n_items++;
      end else begin
        add_request(2'($urandom_range(0, 3)), $urandom, $urandom);
        n_items++;
      end
    end
    total_items = req_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, everything owed received, then a quiet tail.
    while (req_q.size() != 0 || in_valid || due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
